>>> sv/ufcr_pkg.sv
// Package for the UART frame command responder.
// Holds frame constants, result codes and the result record type.
// No dependencies.
package ufcr_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFE;
  localparam logic [7:0] STOP_GOOD    = 8'h01;
  localparam logic [7:0] MODE_READ    = 8'h01;
  localparam logic [7:0] MODE_WRITE   = 8'h02;
  localparam logic [2:0] HEADER_LAST  = 3'd6;

  localparam logic [7:0] ACK_RESET    = 8'h0F;
  localparam logic [7:0] NACK_RESET   = 8'hF0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NACK_CODE = 2'd2;

  localparam logic [1:0] KIND_HOST    = 2'd0;
  localparam logic [1:0] KIND_DEVICE  = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       device_sel;
    logic       commit;
    logic       last;
  } res_t;

endpackage

>>> sv/uart_frame_command_responder.sv
// Top level of the UART frame command responder: header check, payload relay and replies.
// Depends on ufcr_pkg for constants and the result record.
//
//  channel | direction | tdata (low bit up)                       | tuser       | tlast
//  in_     | slave     | rx_byte[7:0], adc_sample[15:8], zero pad  | mode        | -
//  out_    | master    | out_byte[7:0], device_sel[8], commit[9]   | kind        | last
//  cfg_    | slave     | cfg_index selects register, cfg_data     | -           | -
//
// Each accepted item is decoded in the cycle of its transfer and its results (none, one or two)
// are written into a four-entry result queue, so one item is taken every cycle while the queue has room.
// The input is ready while the queue holds two results or fewer; a stop byte of a write
// frame puts two results in, and output stalls back up through the queue.
// Reset (rst_n low, synchronous) returns to hunting and restores register defaults.
module uart_frame_command_responder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // rx_byte, adc_sample, zero pad
  input  logic                           in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // out_byte, device_sel, commit, zero pad
  output logic [1:0]                     out_tuser,  // kind
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ufcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import ufcr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_STOP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  frame_id_r, frame_id_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  pend_mode_r, pend_mode_nxt;
  logic        read_dir_r, read_dir_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;

  logic [5:0]  board_id_r;
  logic [7:0]  ack_code_r;
  logic [7:0]  nack_code_r;

  res_t        queue_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;

  res_t        res0, res1;
  logic [1:0]  n_res;
  logic        in_xfer, out_xfer;
  logic [7:0]  rx_b, smp_b;
  logic        dev_frame, good_stop, hdr_ok;
  logic [7:0]  pay_inc;

  assign in_tready  = (count_r <= 3'd2);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign out_xfer   = out_tvalid && out_tready;
  assign cfg_ready  = 1'b1;

  assign out_tdata  = {6'd0, queue_r[rd_ptr_r].commit, queue_r[rd_ptr_r].device_sel,
                       queue_r[rd_ptr_r].out_byte};
  assign out_tuser  = queue_r[rd_ptr_r].kind;
  assign out_tlast  = queue_r[rd_ptr_r].last;

  assign rx_b      = in_tdata[7:0];
  assign smp_b     = in_tdata[15:8];
  assign dev_frame = (frame_id_r[1:0] != 2'd0);
  assign good_stop = (rx_b == STOP_GOOD);
  assign pay_inc   = pay_cnt_r + 8'd1;
  assign hdr_ok    = (frame_id_r[7:2] == board_id_r) &&
                     ((pend_mode_r == MODE_READ) || (pend_mode_r == MODE_WRITE));

  always_comb begin
    phase_nxt     = phase_r;
    hdr_idx_nxt   = hdr_idx_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    pend_mode_nxt = pend_mode_r;
    read_dir_nxt  = read_dir_r;
    pay_cnt_nxt   = pay_cnt_r;
    n_res         = 2'd0;
    res0          = '{kind: KIND_HOST, out_byte: 8'd0, device_sel: 1'b0, commit: 1'b0,
                      last: 1'b1};
    res1          = '{kind: KIND_VERDICT, out_byte: 8'd0, device_sel: dev_frame,
                      commit: good_stop, last: 1'b1};
    if (in_tuser) begin
      if (phase_r == PH_PAYLOAD && read_dir_r) begin
        n_res         = 2'd1;
        res0.out_byte = smp_b;
        pay_cnt_nxt   = pay_inc;
        if (pay_inc == frame_len_r) begin
          phase_nxt = PH_STOP;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r == 3'd0) begin
            frame_id_nxt = rx_b;
          end
          if (hdr_idx_r == 3'd1) begin
            frame_len_nxt = rx_b;
          end
          if (hdr_idx_r == 3'd2) begin
            pend_mode_nxt = rx_b;
          end
          hdr_idx_nxt = hdr_idx_r + 3'd1;
          if (hdr_idx_r == HEADER_LAST) begin
            hdr_idx_nxt = 3'd0;
            n_res       = 2'd1;
            if (!hdr_ok) begin
              phase_nxt     = PH_HUNT;
              res0.out_byte = nack_code_r;
            end else begin
              read_dir_nxt  = (pend_mode_r == MODE_READ);
              pay_cnt_nxt   = 8'd0;
              phase_nxt     = (frame_len_r == 8'd0) ? PH_STOP : PH_PAYLOAD;
              res0.out_byte = ack_code_r;
            end
          end
        end
        PH_PAYLOAD: begin
          if (!read_dir_r) begin
            n_res           = 2'd1;
            res0.kind       = KIND_DEVICE;
            res0.out_byte   = rx_b;
            res0.device_sel = dev_frame;
            pay_cnt_nxt     = pay_inc;
            if (pay_inc == frame_len_r) begin
              phase_nxt = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          phase_nxt     = PH_HUNT;
          res0.out_byte = good_stop ? ack_code_r : nack_code_r;
          if (read_dir_r) begin
            n_res = 2'd1;
          end else begin
            n_res     = 2'd2;
            res0.last = 1'b0;
          end
        end
        PH_HUNT: begin
          if (rx_b == START_BYTE) begin
            phase_nxt   = PH_HEADER;
            hdr_idx_nxt = 3'd0;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hdr_idx_r   <= 3'd0;
      frame_id_r  <= 8'd0;
      frame_len_r <= 8'd0;
      pend_mode_r <= 8'd0;
      read_dir_r  <= 1'b0;
      pay_cnt_r   <= 8'd0;
      board_id_r  <= 6'd0;
      ack_code_r  <= ACK_RESET;
      nack_code_r <= NACK_RESET;
      wr_ptr_r    <= 2'd0;
      rd_ptr_r    <= 2'd0;
      count_r     <= 3'd0;
    end else begin
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        hdr_idx_r   <= hdr_idx_nxt;
        frame_id_r  <= frame_id_nxt;
        frame_len_r <= frame_len_nxt;
        pend_mode_r <= pend_mode_nxt;
        read_dir_r  <= read_dir_nxt;
        pay_cnt_r   <= pay_cnt_nxt;
        wr_ptr_r    <= wr_ptr_r + n_res;
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + (in_xfer ? {1'b0, n_res} : 3'd0) - {2'd0, out_xfer};
      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          REG_BOARD_ID:  board_id_r  <= cfg_data[5:0];
          REG_ACK_CODE:  ack_code_r  <= cfg_data;
          REG_NACK_CODE: nack_code_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      queue_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

endmodule
